// ===== hdl/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg
// Types, widths and register codes of the coincidence hit time estimator.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int TIME_W   = 32;
    localparam int CHG_W    = 16;
    localparam int CFG_W    = 12;
    localparam int D_W      = CFG_W;
    localparam int UNC_W    = 13;
    localparam int CNT_W    = 2;
    localparam int CIDX_W   = 2;
    localparam int DIFF_W   = TIME_W + 1;
    localparam int SUMQ_W   = CHG_W + 2;
    localparam int QD_W     = CHG_W + D_W;
    localparam int QDD_W    = CHG_W + 2 * D_W;
    localparam int S1_W     = QD_W + 2;
    localparam int S2_W     = QDD_W + 2;
    localparam int S2H_W    = (S2_W + 1) / 2;
    localparam int PA_W     = SUMQ_W + S2H_W;
    localparam int Q2_W     = 2 * SUMQ_W;
    localparam int S1SQ_W   = 2 * S1_W;
    localparam int NUM_W    = SUMQ_W + S2_W;
    localparam int NUM_XW   = NUM_W + 1;
    localparam int VAR_W    = 2 * D_W;
    localparam int OFF_W    = D_W;
    localparam int OXW      = S1_W + 1;
    localparam int TOT_W    = 2 * D_W + 2;
    localparam int SQ_W     = TOT_W + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW  = 2;
    localparam int FIFO_CW  = FIFO_AW + 1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TIME_WINDOW = 2'd0,
        CFG_HIT_RES     = 2'd1,
        CFG_SINGLE_RES  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]         fiber_count;
        logic signed [TIME_W-1:0] time_a;
        logic [CHG_W-1:0]         charge_a;
        logic signed [TIME_W-1:0] time_b;
        logic [CHG_W-1:0]         charge_b;
        logic signed [TIME_W-1:0] time_c;
        logic [CHG_W-1:0]         charge_c;
    } t_in_item;

    typedef struct packed {
        logic signed [TIME_W-1:0] hit_time;
        logic [UNC_W-1:0]         time_uncertainty;
        logic [CNT_W-1:0]         close_count;
        logic                     status;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] window;
        logic [CFG_W-1:0] hit_res;
        logic [CFG_W-1:0] single_res;
    } t_cfg_regs;

    // classified item: offsets and charges of kept fibers, zero when dropped
    typedef struct packed {
        logic signed [TIME_W-1:0] last;
        logic [2:0][D_W-1:0]      d;
        logic [2:0][CHG_W-1:0]    q;
        logic [CNT_W-1:0]         close;
    } t_work;

    typedef struct packed {
        logic signed [TIME_W-1:0] last;
        logic [CNT_W-1:0]         close;
        logic                     zero;
    } t_side;

endpackage

// ===== hdl/chte_front.sv =====
// ----------------------------------------------------------------------------
// chte_front
// Input register and classification: latest time, offsets, window test.
// ----------------------------------------------------------------------------
module chte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chte_pkg::t_in_item i_in_data,
    input  logic [chte_pkg::CFG_W-1:0] i_window,
    input  logic              i_full,
    output logic              o_push,
    output chte_pkg::t_work   o_work
);
    import chte_pkg::*;

    t_in_item r_in;
    logic     r_iv;
    logic     accept;

    logic signed [DIFF_W-1:0] ta, tb, tc, last2, last;
    logic [DIFF_W-1:0]        du [3];
    logic [2:0]               keep;
    logic                     use3;

    assign o_in_stall = r_iv && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_iv && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (accept) begin
            r_iv <= 1'b1;
        end else if (o_push) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        use3  = (r_in.fiber_count == CNT_W'(3));
        ta    = DIFF_W'(r_in.time_a);
        tb    = DIFF_W'(r_in.time_b);
        tc    = DIFF_W'(r_in.time_c);
        last2 = (tb > ta) ? tb : ta;
        last  = (use3 && (tc > last2)) ? tc : last2;
        du[0] = last - ta;
        du[1] = last - tb;
        du[2] = last - tc;
        keep[0] = du[0] <= DIFF_W'(i_window);
        keep[1] = du[1] <= DIFF_W'(i_window);
        keep[2] = use3 && (du[2] <= DIFF_W'(i_window));
        o_work.last  = last[TIME_W-1:0];
        o_work.d[0]  = keep[0] ? du[0][D_W-1:0] : '0;
        o_work.d[1]  = keep[1] ? du[1][D_W-1:0] : '0;
        o_work.d[2]  = keep[2] ? du[2][D_W-1:0] : '0;
        o_work.q[0]  = keep[0] ? r_in.charge_a : '0;
        o_work.q[1]  = keep[1] ? r_in.charge_b : '0;
        o_work.q[2]  = keep[2] ? r_in.charge_c : '0;
        o_work.close = CNT_W'(keep[0]) + CNT_W'(keep[1]) + CNT_W'(keep[2]);
    end

endmodule

// ===== hdl/chte_fifo.sv =====
// ----------------------------------------------------------------------------
// chte_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module chte_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  chte_pkg::t_work i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output chte_pkg::t_work o_head
);
    import chte_pkg::*;

    t_work              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    assign o_full     = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/chte_back.sv =====
// ----------------------------------------------------------------------------
// chte_back
// Arithmetic pipeline: moments, pipelined dividers, square root, output reg.
// ----------------------------------------------------------------------------
module chte_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nonempty,
    input  chte_pkg::t_work      i_head,
    output logic                 o_pop,
    input  chte_pkg::t_cfg_regs  i_cfg,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output chte_pkg::t_out_item  o_out_data
);
    import chte_pkg::*;

    logic en;

    // moment stages
    logic                r1_v, r2_v, r3_v, r4_v, r5_v;
    t_work               r1_w;
    logic [QD_W-1:0]     r2_qd [3];
    logic [D_W-1:0]      r2_d [3];
    logic [QDD_W-1:0]    r3_qdd [3];
    logic [S1_W-1:0]     r3_s1, r4_s1, r5_s1;
    logic [S2_W-1:0]     r4_s2;
    logic [SUMQ_W-1:0]   r2_q, r3_q, r4_q, r5_q;
    logic [S1SQ_W-1:0]   r4_s1sq, r5_s1sq;
    logic [Q2_W-1:0]     r4_q2, r5_q2;
    logic [PA_W-1:0]     r5_pa_lo, r5_pa_hi;
    t_side               r2_s, r3_s, r4_s, r5_s;

    // divider stages, index 0 is the loaded numerator
    logic                r_dv  [VAR_W+1];
    logic [NUM_XW-1:0]   r_vr  [VAR_W+1];
    logic [VAR_W-1:0]    r_vq  [VAR_W+1];
    logic [OXW-1:0]      r_or  [VAR_W+1];
    logic [OFF_W-1:0]    r_oq  [VAR_W+1];
    logic [Q2_W-1:0]     r_dq2 [VAR_W+1];
    logic [SUMQ_W-1:0]   r_dq  [VAR_W+1];
    t_side               r_ds  [VAR_W+1];

    // square root stages
    logic                r_sv  [UNC_W+1];
    logic [SQ_W-1:0]     r_sr  [UNC_W+1];
    logic [UNC_W-1:0]    r_sy  [UNC_W+1];
    logic [TIME_W-1:0]   r_sh  [UNC_W+1];
    t_side               r_ss  [UNC_W+1];

    logic                r_ov;
    t_out_item           r_out;

    logic [NUM_W-1:0]    num_a, num_b;
    logic [TOT_W-1:0]    hr2, sf2, tot;

    assign en          = !r_ov || !i_out_stall;
    assign o_pop       = en && i_nonempty;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r1_v <= i_nonempty;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r_dv[0] <= r5_v;
        end
    end

    always_comb begin
        num_a = NUM_W'(r5_pa_lo) + (NUM_W'(r5_pa_hi) << S2H_W);
        num_b = NUM_W'(r5_s1sq);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w <= i_head;
            // q*d per fiber
            for (int j = 0; j < 3; j++) begin
                r2_qd[j] <= QD_W'(r1_w.q[j]) * QD_W'(r1_w.d[j]);
                r2_d[j]  <= r1_w.d[j];
            end
            r2_q <= SUMQ_W'(r1_w.q[0]) + SUMQ_W'(r1_w.q[1]) + SUMQ_W'(r1_w.q[2]);
            r2_s.last  <= r1_w.last;
            r2_s.close <= r1_w.close;
            r2_s.zero  <= 1'b0;
            // q*d*d per fiber, first moment
            for (int j = 0; j < 3; j++) begin
                r3_qdd[j] <= QDD_W'(r2_qd[j]) * QDD_W'(r2_d[j]);
            end
            r3_s1 <= S1_W'(r2_qd[0]) + S1_W'(r2_qd[1]) + S1_W'(r2_qd[2]);
            r3_q  <= r2_q;
            r3_s  <= r2_s;
            // second moment and squares
            r4_s2   <= S2_W'(r3_qdd[0]) + S2_W'(r3_qdd[1]) + S2_W'(r3_qdd[2]);
            r4_s1sq <= S1SQ_W'(r3_s1) * S1SQ_W'(r3_s1);
            r4_q2   <= Q2_W'(r3_q) * Q2_W'(r3_q);
            r4_q    <= r3_q;
            r4_s1   <= r3_s1;
            r4_s    <= r3_s;
            // Q*S2 in two halves
            r5_pa_lo <= PA_W'(r4_q) * PA_W'(r4_s2[S2H_W-1:0]);
            r5_pa_hi <= PA_W'(r4_q) * PA_W'(r4_s2[S2_W-1:S2H_W]);
            r5_s1sq  <= r4_s1sq;
            r5_q2    <= r4_q2;
            r5_q     <= r4_q;
            r5_s1    <= r4_s1;
            r5_s     <= r4_s;
            // variance numerator clamped at zero, ceiling offset numerator
            r_vr[0]  <= (num_a >= num_b) ? NUM_XW'(num_a - num_b) : '0;
            r_vq[0]  <= '0;
            r_or[0]  <= OXW'(r5_s1) + OXW'(r5_q) - OXW'(1);
            r_oq[0]  <= '0;
            r_dq2[0] <= r5_q2;
            r_dq[0]  <= r5_q;
            r_ds[0].last  <= r5_s.last;
            r_ds[0].close <= r5_s.close;
            r_ds[0].zero  <= (r5_q == '0);
        end
    end

    // one quotient bit per stage, offset quotient in the later stages
    for (genvar k = 0; k < VAR_W; k++) begin : g_div
        localparam int I = VAR_W - 1 - k;
        logic [NUM_XW-1:0] vt;
        logic [OXW-1:0]    ot;
        logic [OFF_W-1:0]  oq_n;
        logic [OXW-1:0]    or_n;

        assign vt = r_vr[k] - (NUM_XW'(r_dq2[k]) << I);

        if (I < OFF_W) begin : g_off
            assign ot   = r_or[k] - (OXW'(r_dq[k]) << I);
            assign or_n = ot[OXW-1] ? r_or[k] : ot;
            assign oq_n = ot[OXW-1] ? r_oq[k] : (r_oq[k] | (OFF_W'(1) << I));
        end else begin : g_nooff
            assign ot   = r_or[k];
            assign or_n = ot;
            assign oq_n = r_oq[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_vr[k+1]  <= vt[NUM_XW-1] ? r_vr[k] : vt;
                r_vq[k+1]  <= vt[NUM_XW-1] ? r_vq[k] : (r_vq[k] | (VAR_W'(1) << I));
                r_or[k+1]  <= or_n;
                r_oq[k+1]  <= oq_n;
                r_dq2[k+1] <= r_dq2[k];
                r_dq[k+1]  <= r_dq[k];
                r_ds[k+1]  <= r_ds[k];
            end
        end
    end

    always_comb begin
        hr2 = TOT_W'(i_cfg.hit_res) * TOT_W'(i_cfg.hit_res);
        sf2 = TOT_W'(i_cfg.single_res) * TOT_W'(i_cfg.single_res);
        tot = TOT_W'(r_vq[VAR_W]) + hr2 + ((r_ds[VAR_W].close == CNT_W'(1)) ? sf2 : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_dv[VAR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr[0] <= SQ_W'(tot);
            r_sy[0] <= '0;
            r_sh[0] <= r_ds[VAR_W].zero ? r_ds[VAR_W].last
                                        : (r_ds[VAR_W].last - TIME_W'(r_oq[VAR_W]));
            r_ss[0] <= r_ds[VAR_W];
        end
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar k = 0; k < UNC_W; k++) begin : g_sqrt
        localparam int I = UNC_W - 1 - k;
        logic [SQ_W-1:0] st;
        logic            take;

        assign st   = (SQ_W'(r_sy[k]) << (I + 1)) + (SQ_W'(1) << (2 * I));
        assign take = r_sr[k] >= st;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sr[k+1] <= take ? (r_sr[k] - st) : r_sr[k];
                r_sy[k+1] <= take ? (r_sy[k] | (UNC_W'(1) << I)) : r_sy[k];
                r_sh[k+1] <= r_sh[k];
                r_ss[k+1] <= r_ss[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv[UNC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit_time         <= r_sh[UNC_W];
            r_out.time_uncertainty <= r_ss[UNC_W].zero ? '0 : r_sy[UNC_W];
            r_out.close_count      <= r_ss[UNC_W].close;
            r_out.status           <= r_ss[UNC_W].zero;
        end
    end

endmodule

// ===== hdl/coincidence_hit_time_estimator_top.sv =====
// pipeline stages in order are the input reg, queue, 5 moment stages,
// numerator stage, 24 divider stages, 1 sum stage, 13 square root stages,
// then output reg; throughput one item per cycle while the output is not
// stalled, set by the fully pipelined divider and square root
// reset: synchronous active low, clears queue and valid bits, loads
// time_window 250, hit_resolution 70, single_fiber_resolution 600
// ----------------------------------------------------------------------------
// coincidence_hit_time_estimator_top
// Charge-weighted hit time and timing uncertainty of two or three fibers.
// ----------------------------------------------------------------------------
module coincidence_hit_time_estimator_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  chte_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output chte_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [chte_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [chte_pkg::CFG_W-1:0]  i_cfg_data
);
    import chte_pkg::*;

    t_cfg_regs r_cfg;
    t_work     push_data, head;
    logic      push, pop, full, nonempty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window     <= CFG_W'(250);
            r_cfg.hit_res    <= CFG_W'(70);
            r_cfg.single_res <= CFG_W'(600);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_WINDOW: r_cfg.window     <= i_cfg_data;
                CFG_HIT_RES:     r_cfg.hit_res    <= i_cfg_data;
                CFG_SINGLE_RES:  r_cfg.single_res <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    chte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_window   (r_cfg.window),
        .i_full     (full),
        .o_push     (push),
        .o_work     (push_data)
    );

    chte_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_data),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    chte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== test/coincidence_hit_time_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_hit_time_estimator_top_tb
// Self-checking bench for the hit time estimator. A local predictor computes
// hit time, uncertainty, close count and status for every accepted item; the
// results are checked in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module coincidence_hit_time_estimator_top_tb;
    import chte_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    logic [CFG_W-1:0] win_reg, hres_reg, sres_reg;
    t_out_item        pending_hits[$];
    int               err_count;
    int               item_count;
    int               result_count;
    int               zero_charge_count;
    int               single_count;
    int               cycle_count;
    bit               hold_off;
    int               hold_cycles;
    bit               quiet_out;

    coincidence_hit_time_estimator_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out_item estimate_hit(input t_in_item it);
        logic signed [TIME_W:0] t[3];
        logic [63:0]  q[3];
        logic signed [TIME_W:0] latest;
        logic [63:0]  qs, s1, s2, d, off, v, tot;
        logic [127:0] a, b;
        int           n, close;
        t_out_item    r;
        t[0] = it.time_a; t[1] = it.time_b; t[2] = it.time_c;
        q[0] = it.charge_a; q[1] = it.charge_b; q[2] = it.charge_c;
        n = (it.fiber_count == 2'd3) ? 3 : 2;
        latest = t[0];
        for (int i = 1; i < n; i++) if (t[i] > latest) latest = t[i];
        qs = 0; s1 = 0; s2 = 0; close = 0;
        for (int i = 0; i < n; i++) begin
            d = 64'(latest - t[i]);
            if (d <= win_reg) begin
                qs += q[i];
                s1 += q[i] * d;
                s2 += q[i] * d * d;
                close++;
            end
        end
        r.close_count = close[1:0];
        if (qs == 0) begin
            r.hit_time = latest[TIME_W-1:0];
            r.time_uncertainty = '0;
            r.status = 1'b1;
            return r;
        end
        off = (s1 + qs - 1) / qs;
        r.hit_time = TIME_W'(latest - $signed({1'b0, off[TIME_W-1:0]}));
        a = 128'(s2) * 128'(qs);
        b = 128'(s1) * 128'(s1);
        v = (a < b) ? 64'd0 : 64'((a - b) / (128'(qs) * 128'(qs)));
        tot = v + 64'(hres_reg) * hres_reg;
        if (close == 1) tot += 64'(sres_reg) * sres_reg;
        r.time_uncertainty = UNC_W'(isqrt(tot));
        r.status = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("mismatch %s: got %0h expected %0h (result %0d)",
                 what, got, want, result_count);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", o_out_data, 0);
            end else begin
                want = pending_hits.pop_front();
                if (o_out_data.hit_time !== want.hit_time)
                    report_mismatch("hit_time", o_out_data.hit_time, want.hit_time);
                if (o_out_data.time_uncertainty !== want.time_uncertainty)
                    report_mismatch("time_uncertainty", o_out_data.time_uncertainty,
                                    want.time_uncertainty);
                if (o_out_data.close_count !== want.close_count)
                    report_mismatch("close_count", o_out_data.close_count,
                                    want.close_count);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
            end
            result_count++;
        end
    end

    // receiver stall: random gaps, a long counted hold-off, or none while quiet_out is set
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 200) hold_off <= 1'b0;
        end else if (quiet_out) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 20) ||
                           (($urandom_range(0, 99) == 0) ? 1'b1 : 1'b0);
        end
    end

    // valid drops only when there is a real gap
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input t_in_item it, input bit gaps = 1);
        t_out_item want_hit;
        if (gaps) idle_gap();
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want_hit = estimate_hit(it);
        pending_hits = {pending_hits, want_hit};
        item_count++;
        if (want_hit.status) zero_charge_count++;
        if (want_hit.close_count == 1) single_count++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TIME_WINDOW: win_reg  = val;
            CFG_HIT_RES:     hres_reg = val;
            default:         sres_reg = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] cnt,
        input logic [31:0] ta, input logic [15:0] qa, input logic [31:0] tb,
        input logic [15:0] qb, input logic [31:0] tc, input logic [15:0] qc);
        t_in_item it;
        it.fiber_count = cnt;
        it.time_a = ta; it.charge_a = qa;
        it.time_b = tb; it.charge_b = qb;
        it.time_c = tc; it.charge_c = qc;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        logic [31:0] base;
        int span;
        it = make_item(2'($urandom), $urandom, 16'($urandom), $urandom, 16'($urandom),
                       $urandom, 16'($urandom));
        if ($urandom_range(0, 9) < 8) begin
            // clustered times spread over the window plus 40, so some fibers fall just outside it
            base = $urandom;
            span = win_reg + 40;
            it.time_a = base - $urandom_range(0, span);
            it.time_b = base - $urandom_range(0, span);
            it.time_c = base - $urandom_range(0, span);
            if ($urandom_range(0, 9) == 0) it.charge_a = 0;
            if ($urandom_range(0, 9) == 0) it.charge_b = 0;
            if ($urandom_range(0, 9) == 0) it.charge_c = 0;
            if ($urandom_range(0, 7) == 0) it.charge_b = 16'hffff;
        end
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_item(2'd2, 32'd1000, 16'd10, 32'd900, 16'd20, 32'd0, 16'd0));
        send_item(make_item(2'd3, 32'd1000, 16'd10, 32'd900, 16'd20, 32'd800, 16'd5));
        send_item(make_item(2'd0, 32'd5, 16'd1, 32'd5, 16'd1, 32'd7, 16'd9));
        send_item(make_item(2'd1, 32'd0, 16'd3, 32'd251, 16'd4, 32'd0, 16'd0));
        send_item(make_item(2'd3, 32'h7fffffff, 16'hffff, 32'h80000000, 16'hffff,
                            32'h7fffff06, 16'hffff));
        send_item(make_item(2'd3, 32'h80000000, 16'hffff, 32'h80000000, 16'hffff,
                            32'h80000000, 16'hffff));
        send_item(make_item(2'd2, 32'd100, 16'd0, 32'd90, 16'd0, 32'd0, 16'd0));
        send_item(make_item(2'd3, 32'd100, 16'd0, 32'd0, 16'd50, 32'd99, 16'd0));
        send_item(make_item(2'd3, 32'd0, 16'd1, 32'd250, 16'hffff, 32'd250, 16'd1));
        send_item(make_item(2'd3, 32'hffffffff, 16'h8000, 32'h0, 16'h1, 32'd250, 16'h7fff));
        send_item(make_item(2'd2, 32'd100, 16'hffff, 32'd100, 16'hffff, 32'd0, 16'd0));
        send_item(make_item(2'd3, 32'haaaaaaaa, 16'haaaa, 32'h55555555, 16'h5555,
                            32'haaaaaaab, 16'h5555));
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_TIME_WINDOW, 12'hfff);
        write_reg(CFG_HIT_RES, 12'hfff);
        write_reg(CFG_SINGLE_RES, 12'hfff);
        send_item(make_item(2'd3, 32'd4095, 16'hffff, 32'd0, 16'hffff, 32'd4096, 16'h1));
        send_item(make_item(2'd3, 32'd0, 16'hffff, 32'd4095, 16'h1, 32'd2000, 16'hffff));
        send_item(make_item(2'd2, 32'd0, 16'd9, 32'd9000, 16'd9, 32'd0, 16'd0));
        wait_drained();
        write_reg(CFG_TIME_WINDOW, 12'd0);
        write_reg(CFG_HIT_RES, 12'd0);
        write_reg(CFG_SINGLE_RES, 12'd0);
        send_item(make_item(2'd3, 32'd7, 16'd3, 32'd7, 16'd4, 32'd6, 16'd5));
        send_item(make_item(2'd2, 32'd7, 16'd3, 32'd8, 16'd4, 32'd0, 16'd0));
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) send_item(random_item());
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 0;
        hold_off = 1'b1;
        for (int k = 0; k < 80; k++) send_item(random_item(), 0);
        wait_drained();
    endtask

    task automatic test_streaming();
        quiet_out = 1'b1;
        for (int k = 0; k < 100; k++) send_item(random_item(), 0);
        wait_drained();
        quiet_out = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_TIME_WINDOW; i_cfg_data = '0;
        win_reg = 12'd250; hres_reg = 12'd70; sres_reg = 12'd600;
        err_count = 0; item_count = 0; result_count = 0; cycle_count = 0;
        zero_charge_count = 0; single_count = 0;
        hold_off = 1'b0; hold_cycles = 0; quiet_out = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_extremes();
        write_reg(CFG_TIME_WINDOW, 12'd250);
        write_reg(CFG_HIT_RES, 12'd70);
        write_reg(CFG_SINGLE_RES, 12'd600);
        test_random(500);
        test_backpressure();
        test_streaming();
        write_reg(CFG_TIME_WINDOW, 12'd30);
        write_reg(CFG_HIT_RES, 12'($urandom_range(0, 4095)));
        write_reg(CFG_SINGLE_RES, 12'($urandom_range(0, 4095)));
        test_random(400);
        write_reg(CFG_TIME_WINDOW, 12'hfff);
        test_random(400);

        $display("covered %0d items, %0d results, %0d zero-charge, %0d single-fiber",
                 item_count, result_count, zero_charge_count, single_count);
        $display("register settings swept through both extremes and random values");
        if (err_count == 0 && pending_hits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/chte_pkg.sv
hdl/chte_front.sv
hdl/chte_fifo.sv
hdl/chte_back.sv
hdl/coincidence_hit_time_estimator_top.sv
test/coincidence_hit_time_estimator_top_tb.sv
